### sv/vfc_pkg.sv
package vfc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DRAG_FACTOR = 2'd0,
    CFG_SPEED_FLOOR = 2'd1
  } cfg_idx_e;

  // Slack added to the floor speed before the speed compares, in Q16.16 LSBs.
  localparam int unsigned EPSILON_LSB = 1;

  // One root bit per square-root step, one quotient bit per division step.
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 32;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [15:0]        time_step;
  } vfc_in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               changed;
  } vfc_out_t;

  // Decision that rides alongside the square-root and division stages.
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic [31:0] res_x;
    logic [31:0] res_y;
    logic        changed;
    logic        floor_sel;
  } vfc_side_t;

endpackage

### sv/velocity_friction_clamp_core.sv
// Proportional drag on a 2D particle velocity (signed Q16.16), with a speed floor.
//
// Input channel: a beat on item_i is taken at every rising edge where start_i is high
// and busy_o is low. busy_o stays low, so a new beat can enter in every cycle.
// Output channel: done_o is high for exactly one cycle with the result beat on
// result_o. The receiver cannot stall, so no backpressure exists anywhere inside.
// Throughput is one beat per cycle. The pipeline depth is set by the floor path:
// a 32-step square root for the old speed followed by a 32-step divider that
// scales the floor speed along the old direction, one bit per pipeline stage.
// Every beat takes the full pipeline, whether or not it needs the floor path.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the clock
// edge (index 0 drag factor, index 1 speed floor; other indexes are ignored).
// Write registers only while no beat is in flight.
// Reset clears both registers to zero and drops every in-flight beat; no result
// appears for a beat that was inside the pipeline when reset arrived.
module velocity_friction_clamp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  vfc_pkg::vfc_in_t    item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [30:0]         cfg_data_i,
  output logic                done_o,
  output vfc_pkg::vfc_out_t   result_o
);
  import vfc_pkg::*;

  function automatic logic [31:0] encode(input logic neg, input logic [31:0] mag);
    encode = neg ? (~mag + 32'd1) : mag;
  endfunction

  // The pipeline never holds off the sender.
  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // Configuration registers. The squared floor limit is kept in a register of
  // its own; it settles in the cycle after a write, well before a beat needs it.
  // --------------------------------------------------------------------------
  logic [23:0] drag_q;
  logic [30:0] floor_q;
  logic [63:0] lim2_q, lim2_d;
  logic [31:0] lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q  <= '0;
      floor_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DRAG_FACTOR: drag_q  <= cfg_data_i[23:0];
        CFG_SPEED_FLOOR: floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lim    = 32'(floor_q) + 32'(EPSILON_LSB);
  assign lim2_d = 64'(lim) * 64'(lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim2_q <= 64'd1;
    end else begin
      lim2_q <= lim2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input beat registered. Magnitudes and the drag step k are formed
  // from it: k = round(drag * dt / 2^16).
  // --------------------------------------------------------------------------
  logic        s1_vld_q;
  logic [31:0] s1_vx_q, s1_vy_q;
  logic [15:0] s1_dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_vx_q <= item_i.vel_x;
    s1_vy_q <= item_i.vel_y;
    s1_dt_q <= item_i.time_step;
  end

  logic        s1_nx, s1_ny;
  logic [31:0] s1_mx, s1_my;
  logic [39:0] s1_kprod;

  // A negative full-scale value gives a magnitude of 2^31, which still fits.
  assign s1_nx    = s1_vx_q[31];
  assign s1_ny    = s1_vy_q[31];
  assign s1_mx    = s1_nx ? (~s1_vx_q + 32'd1) : s1_vx_q;
  assign s1_my    = s1_ny ? (~s1_vy_q + 32'd1) : s1_vy_q;
  assign s1_kprod = 40'(drag_q) * 40'(s1_dt_q) + 40'h8000;

  // --------------------------------------------------------------------------
  // Stage 2: drag products m*k, squared magnitudes and floor * m, all in parallel.
  // --------------------------------------------------------------------------
  logic        s2_vld_q;
  logic [31:0] s2_vx_q, s2_vy_q, s2_mx_q, s2_my_q;
  logic        s2_nx_q, s2_ny_q, s2_zero_q;
  logic [23:0] s2_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_vx_q   <= s1_vx_q;
    s2_vy_q   <= s1_vy_q;
    s2_mx_q   <= s1_mx;
    s2_my_q   <= s1_my;
    s2_nx_q   <= s1_nx;
    s2_ny_q   <= s1_ny;
    s2_zero_q <= (s1_mx == 32'd0) && (s1_my == 32'd0);
    s2_k_q    <= s1_kprod[39:16];
  end

  logic [55:0] s2_dpx, s2_dpy;
  logic [63:0] s2_sqx, s2_sqy;
  logic [61:0] s2_tmx, s2_tmy;

  assign s2_dpx = 56'(s2_mx_q) * 56'(s2_k_q) + 56'h8000;
  assign s2_dpy = 56'(s2_my_q) * 56'(s2_k_q) + 56'h8000;
  assign s2_sqx = 64'(s2_mx_q) * 64'(s2_mx_q);
  assign s2_sqy = 64'(s2_my_q) * 64'(s2_my_q);
  assign s2_tmx = 62'(floor_q) * 62'(s2_mx_q);
  assign s2_tmy = 62'(floor_q) * 62'(s2_my_q);

  // --------------------------------------------------------------------------
  // Stage 3: new magnitudes, sign-flip detection, their squares and |v|^2.
  // --------------------------------------------------------------------------
  logic        s3_vld_q;
  logic [31:0] s3_vx_q, s3_vy_q, s3_mx_q, s3_my_q;
  logic        s3_nx_q, s3_ny_q, s3_zero_q;
  logic [39:0] s3_dx_q, s3_dy_q;
  logic [63:0] s3_sqx_q, s3_sqy_q;
  logic [61:0] s3_tmx_q, s3_tmy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_vx_q   <= s2_vx_q;
    s3_vy_q   <= s2_vy_q;
    s3_mx_q   <= s2_mx_q;
    s3_my_q   <= s2_my_q;
    s3_nx_q   <= s2_nx_q;
    s3_ny_q   <= s2_ny_q;
    s3_zero_q <= s2_zero_q;
    s3_dx_q   <= s2_dpx[55:16];
    s3_dy_q   <= s2_dpy[55:16];
    s3_sqx_q  <= s2_sqx;
    s3_sqy_q  <= s2_sqy;
    s3_tmx_q  <= s2_tmx;
    s3_tmy_q  <= s2_tmy;
  end

  logic        s3_fx, s3_fy;
  logic [31:0] s3_ax, s3_ay;
  logic [63:0] s3_axsq, s3_aysq, s3_cur2;

  // Zero counts as positive, so a negative component flips already when it
  // reaches zero, a positive one only when it would go below zero.
  assign s3_fx   = s3_nx_q ? (s3_dx_q >= 40'(s3_mx_q)) : (s3_dx_q > 40'(s3_mx_q));
  assign s3_fy   = s3_ny_q ? (s3_dy_q >= 40'(s3_my_q)) : (s3_dy_q > 40'(s3_my_q));
  assign s3_ax   = (s3_dx_q <= 40'(s3_mx_q)) ? (s3_mx_q - s3_dx_q[31:0]) : 32'd0;
  assign s3_ay   = (s3_dy_q <= 40'(s3_my_q)) ? (s3_my_q - s3_dy_q[31:0]) : 32'd0;
  assign s3_axsq = 64'(s3_ax) * 64'(s3_ax);
  assign s3_aysq = 64'(s3_ay) * 64'(s3_ay);
  assign s3_cur2 = s3_sqx_q + s3_sqy_q;

  // --------------------------------------------------------------------------
  // Stage 4: pick the outcome. Everything but the floor direction is final here.
  // --------------------------------------------------------------------------
  logic        s4_vld_q;
  logic [31:0] s4_vx_q, s4_vy_q, s4_ax_q, s4_ay_q;
  logic        s4_nx_q, s4_ny_q, s4_zero_q, s4_fx_q, s4_fy_q;
  logic [63:0] s4_axsq_q, s4_aysq_q, s4_cur2_q;
  logic [61:0] s4_tmx_q, s4_tmy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_vx_q   <= s3_vx_q;
    s4_vy_q   <= s3_vy_q;
    s4_ax_q   <= s3_ax;
    s4_ay_q   <= s3_ay;
    s4_nx_q   <= s3_nx_q;
    s4_ny_q   <= s3_ny_q;
    s4_zero_q <= s3_zero_q;
    s4_fx_q   <= s3_fx;
    s4_fy_q   <= s3_fy;
    s4_axsq_q <= s3_axsq;
    s4_aysq_q <= s3_aysq;
    s4_cur2_q <= s3_cur2;
    s4_tmx_q  <= s3_tmx_q;
    s4_tmy_q  <= s3_tmy_q;
  end

  vfc_side_t s4_side;
  logic [63:0] s4_new2;

  assign s4_new2 = s4_axsq_q + s4_aysq_q;

  always_comb begin
    s4_side.neg_x     = s4_nx_q;
    s4_side.neg_y     = s4_ny_q;
    s4_side.res_x     = s4_vx_q;
    s4_side.res_y     = s4_vy_q;
    s4_side.changed   = 1'b0;
    s4_side.floor_sel = 1'b0;
    if ((drag_q != 24'd0) && !s4_zero_q) begin
      if (floor_q == 31'd0) begin
        // Sign-flip mode: a flipped component stops dead.
        s4_side.res_x   = s4_fx_q ? 32'd0 : encode(s4_nx_q, s4_ax_q);
        s4_side.res_y   = s4_fy_q ? 32'd0 : encode(s4_ny_q, s4_ay_q);
        s4_side.changed = 1'b1;
      end else if (s4_cur2_q > lim2_q) begin
        // Particles already at or below the floor are left alone.
        s4_side.changed = 1'b1;
        if (s4_fx_q || s4_fy_q || (s4_new2 <= lim2_q)) begin
          s4_side.floor_sel = 1'b1;
        end else begin
          s4_side.res_x = encode(s4_nx_q, s4_ax_q);
          s4_side.res_y = encode(s4_ny_q, s4_ay_q);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square root of |v|^2, one root bit per stage (digit-by-digit, two radicand
  // bits consumed per stage).
  // --------------------------------------------------------------------------
  logic        sq_vld_q  [SQRT_STEPS+1];
  logic [63:0] sq_x_q    [SQRT_STEPS+1];
  logic [33:0] sq_rem_q  [SQRT_STEPS+1];
  logic [31:0] sq_root_q [SQRT_STEPS+1];
  logic [61:0] sq_tmx_q  [SQRT_STEPS+1];
  logic [61:0] sq_tmy_q  [SQRT_STEPS+1];
  vfc_side_t   sq_side_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else begin
      sq_vld_q[0] <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_x_q[0]    <= s4_cur2_q;
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    sq_tmx_q[0]  <= s4_tmx_q;
    sq_tmy_q[0]  <= s4_tmy_q;
    sq_side_q[0] <= s4_side;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [35:0] rem2;
    logic [35:0] trial;
    logic        ge;

    assign rem2  = {sq_rem_q[j], sq_x_q[j][63:62]};
    assign trial = {2'b00, sq_root_q[j], 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j+1] <= 1'b0;
      end else begin
        sq_vld_q[j+1] <= sq_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_x_q[j+1]    <= {sq_x_q[j][61:0], 2'b00};
      sq_rem_q[j+1]  <= ge ? 34'(rem2 - trial) : rem2[33:0];
      sq_root_q[j+1] <= {sq_root_q[j][30:0], ge};
      sq_tmx_q[j+1]  <= sq_tmx_q[j];
      sq_tmy_q[j+1]  <= sq_tmy_q[j];
      sq_side_q[j+1] <= sq_side_q[j];
    end
  end

  // --------------------------------------------------------------------------
  // Floor direction: q = round(T * m / mag) = (2*T*m + mag) / (2*mag), both
  // components side by side, one quotient bit per stage from the top.
  // mag >= m, so the quotient never exceeds T and fits in 32 bits.
  // --------------------------------------------------------------------------
  logic        dv_vld_q  [DIV_STEPS+1];
  logic [63:0] dv_remx_q [DIV_STEPS+1];
  logic [63:0] dv_remy_q [DIV_STEPS+1];
  logic [32:0] dv_den_q  [DIV_STEPS+1];
  logic [31:0] dv_qx_q   [DIV_STEPS+1];
  logic [31:0] dv_qy_q   [DIV_STEPS+1];
  vfc_side_t   dv_side_q [DIV_STEPS+1];

  logic [31:0] sq_mag;

  assign sq_mag = sq_root_q[SQRT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= sq_vld_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_remx_q[0] <= {1'b0, sq_tmx_q[SQRT_STEPS], 1'b0} + 64'(sq_mag);
    dv_remy_q[0] <= {1'b0, sq_tmy_q[SQRT_STEPS], 1'b0} + 64'(sq_mag);
    dv_den_q[0]  <= {sq_mag, 1'b0};
    dv_qx_q[0]   <= '0;
    dv_qy_q[0]   <= '0;
    dv_side_q[0] <= sq_side_q[SQRT_STEPS];
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [64:0] dsh;
    logic        gex, gey;

    assign dsh = 65'(dv_den_q[j]) << (DIV_STEPS - 1 - j);
    assign gex = 65'(dv_remx_q[j]) >= dsh;
    assign gey = 65'(dv_remy_q[j]) >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_remx_q[j+1] <= gex ? (dv_remx_q[j] - dsh[63:0]) : dv_remx_q[j];
      dv_remy_q[j+1] <= gey ? (dv_remy_q[j] - dsh[63:0]) : dv_remy_q[j];
      dv_den_q[j+1]  <= dv_den_q[j];
      dv_qx_q[j+1]   <= {dv_qx_q[j][30:0], gex};
      dv_qy_q[j+1]   <= {dv_qy_q[j][30:0], gey};
      dv_side_q[j+1] <= dv_side_q[j];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: one-cycle strobe with the final beat.
  // --------------------------------------------------------------------------
  vfc_side_t   fin_side;
  logic [31:0] fin_qx, fin_qy;
  logic        done_q;
  vfc_out_t    result_q;

  assign fin_side = dv_side_q[DIV_STEPS];
  assign fin_qx   = dv_qx_q[DIV_STEPS];
  assign fin_qy   = dv_qy_q[DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.changed <= fin_side.changed;
    if (fin_side.floor_sel) begin
      result_q.new_vel_x <= encode(fin_side.neg_x, fin_qx);
      result_q.new_vel_y <= encode(fin_side.neg_y, fin_qy);
    end else begin
      result_q.new_vel_x <= fin_side.res_x;
      result_q.new_vel_y <= fin_side.res_y;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The floor path is only chosen with a nonzero floor and a written result.
  a_floor_needs_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q && s4_side.floor_sel |-> (floor_q != 31'd0) && s4_side.changed)
    else $error("floor path chosen without a speed floor");

  // A scaled floor component never exceeds the floor speed itself.
  a_floor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[DIV_STEPS] && fin_side.floor_sel |->
      (fin_qx <= 32'(floor_q)) && (fin_qy <= 32'(floor_q)))
    else $error("floor direction larger than the floor speed");

  // The root leaves a remainder no larger than twice the root.
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q[SQRT_STEPS] |-> 34'(sq_rem_q[SQRT_STEPS]) <= {1'b0, sq_mag, 1'b0})
    else $error("square root remainder out of range");

  // A result strobe always follows a beat that enters the square root.
  a_strobe_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q[0] |=> ##(SQRT_STEPS + DIV_STEPS + 1) done_o)
    else $error("result strobe missing for an accepted beat");

endmodule
